FILE: design/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types and constants of the eased scroll animator: channel payloads,
// command codes, register indexes, state machine encodings and the
// interface records between the core and its easing unit.
// ----------------------------------------------------------------------------
package esa_pkg;

  // Command codes of an input item.
  localparam logic [2:0] CMD_MOVE_BY = 3'd0;
  localparam logic [2:0] CMD_MOVE_TO = 3'd1;
  localparam logic [2:0] CMD_JUMP    = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_CANCEL  = 3'd4;

  // Register word indexes on the configuration port (byte address = 4 * index).
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_SMOOTH_ENABLE = 1'b0;
  localparam logic REG_DURATION_MS   = 1'b1;

  // Register reset values.
  localparam logic        SMOOTH_RESET   = 1'b1;
  localparam logic [15:0] DURATION_RESET = 16'd150;

  // Easing arithmetic: t is Q0.16, one is 2^16.
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned MUL_A_W     = 33;
  localparam int unsigned MUL_B_W     = 17;
  localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;

  // Input item payload.
  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] amount;
    logic signed [31:0] bound_a;
    logic signed [31:0] bound_b;
    logic signed [31:0] current_pos;
    logic        [31:0] now_ms;
  } esa_req_t;

  // Result item payload.
  typedef struct packed {
    logic               write_valid;
    logic signed [31:0] position;
    logic               accepted;
    logic               busy_res;
  } esa_rsp_t;

  // Request from the core to the easing unit.
  typedef struct packed {
    logic               start;
    logic        [15:0] elapsed;
    logic        [15:0] dur;
    logic signed [31:0] glide_start;
    logic signed [31:0] glide_target;
  } ease_req_t;

  // Answer of the easing unit.
  typedef struct packed {
    logic               done;
    logic signed [31:0] position;
  } ease_rsp_t;

  // Sequencer of the core.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ORDER,
    S_BASE,
    S_SUM,
    S_CLAMP,
    S_DECIDE,
    S_TIME,
    S_EASE,
    S_DELIVER
  } core_state_t;

  // Sequencer of the easing unit.
  typedef enum logic [2:0] {
    E_IDLE,
    E_DIV,
    E_SQUARE,
    E_CUBE,
    E_EASE,
    E_STEP,
    E_ADD
  } ease_state_t;

endpackage

FILE: design/esa_stream_if.sv
// ----------------------------------------------------------------------------
// esa_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface esa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/eased_scroll_animator_core.sv
// ----------------------------------------------------------------------------
// eased_scroll_animator_core
// Smooth scroll position generator with ease-out cubic glides.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (move by, move to, jump, tick, cancel) with
//   the range bounds, the shown position and a millisecond timestamp. rsp
//   returns exactly one result item per command: a position to write when
//   write_valid is set, whether a move was taken, and whether a glide is
//   still in flight afterwards.
//   Items are handled one at a time by a small sequencer. Moves and jumps
//   pass the order, base, sum, clamp and decide states on the way to the
//   result register; a tick during a glide runs the easing unit with its
//   16-step divider and three passes through the shared multiplier. Other
//   ticks, cancels and unused commands pass only the time or decide state.
//   A new item waits until the last result is loaded and the sequencer idles.
//   req.ready is high whenever the sequencer is idle, also while an earlier
//   result waits in the output register.
//   If the receiver stalls, a finished result waits until the output
//   register frees, and no new item is taken meanwhile.
//   Reset clears any glide, sets smooth_enable to 1 and duration_ms to 150.
//   Registers are written over the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module eased_scroll_animator_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [esa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  esa_stream_if.sink                       req,
  esa_stream_if.source                     rsp
);

  esa_pkg::core_state_t state;
  esa_pkg::core_state_t state_next;

  // Configuration registers.
  logic        smooth_enable;
  logic [15:0] duration_ms;

  // Glide state.
  logic                  in_flight;
  logic signed [31:0]    glide_start;
  logic signed [31:0]    glide_target;
  logic [TIME_WIDTH-1:0] start_stamp;

  // Captured item and working values.
  logic [2:0]            cmd;
  logic signed [31:0]    amount;
  logic signed [31:0]    bound_a;
  logic signed [31:0]    bound_b;
  logic signed [31:0]    current_pos;
  logic [31:0]           now_ms;
  logic signed [31:0]    range_low;
  logic signed [31:0]    range_high;
  logic signed [31:0]    base;
  logic signed [32:0]    goal;
  logic signed [31:0]    target;

  // Pending result and output register.
  logic                  res_write;
  logic signed [31:0]    res_position;
  logic                  res_accepted;
  logic                  out_valid;
  esa_pkg::esa_rsp_t     out_data;

  // Combinational helpers.
  logic                  cfg_write;
  logic                  jump_mode;
  logic signed [31:0]    base_src;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [15:0]           dur_eff;
  logic                  glide_over;
  logic                  in_take;
  logic                  out_load;
  logic                  ease_start;
  esa_pkg::ease_req_t    ease_req;
  esa_pkg::ease_rsp_t    ease_rsp;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == esa_pkg::REG_DURATION_MS) ? {16'b0, duration_ms}
                                                            : {31'b0, smooth_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_enable <= esa_pkg::SMOOTH_RESET;
      duration_ms   <= esa_pkg::DURATION_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == esa_pkg::REG_SMOOTH_ENABLE) begin
        smooth_enable <= pwdata[0];
      end else begin
        duration_ms <= pwdata[15:0];
      end
    end
  end

  // Shared decisions.
  assign jump_mode  = !smooth_enable || (duration_ms == 16'd0);
  assign base_src   = in_flight ? glide_target : current_pos;
  assign elapsed    = now_ms[TIME_WIDTH-1:0] - start_stamp;
  assign dur_eff    = (duration_ms == 16'd0) ? 16'd1 : duration_ms;
  assign glide_over = (elapsed >= {{(TIME_WIDTH-16){1'b0}}, dur_eff});

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      esa_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.payload.cmd == esa_pkg::CMD_MOVE_BY || req.payload.cmd == esa_pkg::CMD_MOVE_TO ||
              req.payload.cmd == esa_pkg::CMD_JUMP) begin
            state_next = esa_pkg::S_ORDER;
          end else if (req.payload.cmd == esa_pkg::CMD_TICK) begin
            state_next = esa_pkg::S_TIME;
          end else begin
            state_next = esa_pkg::S_DECIDE;
          end
        end
      end
      esa_pkg::S_ORDER:  state_next = esa_pkg::S_BASE;
      esa_pkg::S_BASE:   state_next = esa_pkg::S_SUM;
      esa_pkg::S_SUM:    state_next = esa_pkg::S_CLAMP;
      esa_pkg::S_CLAMP:  state_next = esa_pkg::S_DECIDE;
      esa_pkg::S_DECIDE: state_next = esa_pkg::S_DELIVER;
      esa_pkg::S_TIME: begin
        if (in_flight && !glide_over) begin
          state_next = esa_pkg::S_EASE;
        end else begin
          state_next = esa_pkg::S_DELIVER;
        end
      end
      esa_pkg::S_EASE: if (ease_rsp.done) state_next = esa_pkg::S_DELIVER;
      esa_pkg::S_DELIVER: if (!out_valid || rsp.ready) state_next = esa_pkg::S_IDLE;
      default: state_next = esa_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_take    = 1'b0;
    out_load   = 1'b0;
    ease_start = 1'b0;
    case (state)
      esa_pkg::S_IDLE:    in_take    = req.valid;
      esa_pkg::S_TIME:    ease_start = in_flight && !glide_over;
      esa_pkg::S_DELIVER: out_load   = !out_valid || rsp.ready;
      default: begin
      end
    endcase
  end

  assign req.ready = (state == esa_pkg::S_IDLE);

  // Easing unit.
  assign ease_req.start        = ease_start;
  assign ease_req.elapsed      = elapsed[15:0];
  assign ease_req.dur          = dur_eff;
  assign ease_req.glide_start  = glide_start;
  assign ease_req.glide_target = glide_target;

  esa_ease_unit u_ease (
    .clk (clk),
    .rst (rst),
    .req (ease_req),
    .rsp (ease_rsp)
  );

  // Control registers: sequencer, glide flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= esa_pkg::S_IDLE;
      in_flight <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == esa_pkg::S_DECIDE) begin
        case (cmd)
          esa_pkg::CMD_MOVE_BY, esa_pkg::CMD_MOVE_TO: begin
            if (!(cmd == esa_pkg::CMD_MOVE_BY && amount == 32'sd0)) begin
              if (jump_mode) begin
                if (target != current_pos) in_flight <= 1'b0;
              end else if (target != current_pos || in_flight) begin
                in_flight <= 1'b1;
              end
            end
          end
          esa_pkg::CMD_JUMP, esa_pkg::CMD_CANCEL: in_flight <= 1'b0;
          default: begin
          end
        endcase
      end else if (state == esa_pkg::S_TIME && in_flight && glide_over) begin
        in_flight <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Glide state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      glide_start  <= '0;
      glide_target <= '0;
      start_stamp  <= '0;
    end else if (state == esa_pkg::S_DECIDE && !jump_mode &&
                 (cmd == esa_pkg::CMD_MOVE_BY || cmd == esa_pkg::CMD_MOVE_TO) &&
                 !(cmd == esa_pkg::CMD_MOVE_BY && amount == 32'sd0) &&
                 (target != current_pos || in_flight)) begin
      glide_start  <= current_pos;
      glide_target <= target;
      start_stamp  <= now_ms[TIME_WIDTH-1:0];
    end
  end

  // Item capture, range and goal computation, result forming.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd         <= req.payload.cmd;
      amount      <= req.payload.amount;
      bound_a     <= req.payload.bound_a;
      bound_b     <= req.payload.bound_b;
      current_pos <= req.payload.current_pos;
      now_ms      <= req.payload.now_ms;
    end
    case (state)
      esa_pkg::S_ORDER: begin
        range_low  <= (bound_a < bound_b) ? bound_a : bound_b;
        range_high <= (bound_a < bound_b) ? bound_b : bound_a;
      end
      esa_pkg::S_BASE: begin
        if (base_src < range_low) begin
          base <= range_low;
        end else if (base_src > range_high) begin
          base <= range_high;
        end else begin
          base <= base_src;
        end
      end
      esa_pkg::S_SUM: begin
        if (cmd == esa_pkg::CMD_MOVE_BY) begin
          goal <= {base[31], base} + {amount[31], amount};
        end else begin
          goal <= {amount[31], amount};
        end
      end
      esa_pkg::S_CLAMP: begin
        if (goal < $signed({range_low[31], range_low})) begin
          target <= range_low;
        end else if (goal > $signed({range_high[31], range_high})) begin
          target <= range_high;
        end else begin
          target <= goal[31:0];
        end
      end
      esa_pkg::S_DECIDE: begin
        res_write    <= 1'b0;
        res_position <= '0;
        res_accepted <= 1'b0;
        case (cmd)
          esa_pkg::CMD_MOVE_BY, esa_pkg::CMD_MOVE_TO: begin
            if (!(cmd == esa_pkg::CMD_MOVE_BY && amount == 32'sd0)) begin
              if (jump_mode) begin
                if (target != current_pos) begin
                  res_write    <= 1'b1;
                  res_position <= target;
                  res_accepted <= 1'b1;
                end
              end else if (target != current_pos || in_flight) begin
                res_accepted <= 1'b1;
              end
            end
          end
          esa_pkg::CMD_JUMP: begin
            res_write    <= 1'b1;
            res_position <= target;
            res_accepted <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      esa_pkg::S_TIME: begin
        res_accepted <= 1'b0;
        res_write    <= in_flight;
        res_position <= (in_flight && glide_over) ? glide_target : 32'sd0;
      end
      esa_pkg::S_EASE: begin
        if (ease_rsp.done) res_position <= ease_rsp.position;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data.write_valid <= res_write;
      out_data.position    <= res_position;
      out_data.accepted    <= res_accepted;
      out_data.busy_res    <= in_flight;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

endmodule

FILE: design/esa_ease_unit.sv
// ----------------------------------------------------------------------------
// esa_ease_unit
// Iterative ease-out cubic evaluator. A restoring divider forms
// t = elapsed * 2^16 / dur one bit per cycle, then one shared 33x17
// multiplier is used three times: u*u, u^2*u and |diff|*eased.
// ----------------------------------------------------------------------------
module esa_ease_unit (
  input  logic              clk,
  input  logic              rst,
  input  esa_pkg::ease_req_t req,
  output esa_pkg::ease_rsp_t rsp
);

  esa_pkg::ease_state_t state;
  esa_pkg::ease_state_t state_next;

  logic [15:0]                     dur;
  logic [15:0]                     rem;
  logic [15:0]                     quot;
  logic [esa_pkg::DIV_CNT_W-1:0]   cnt;
  logic signed [31:0]              start;
  logic signed [31:0]              target;
  logic signed [32:0]              diff;
  logic [32:0]                     mag;
  logic [16:0]                     eased;
  logic [esa_pkg::MUL_P_W-1:0]     prod;
  logic                            done;
  logic signed [31:0]              position;

  logic [16:0]                     u;
  logic [16:0]                     rem_dbl;
  logic                            div_bit;
  logic                            div_last;
  logic [esa_pkg::MUL_A_W-1:0]     mul_a;
  logic [esa_pkg::MUL_B_W-1:0]     mul_b;
  logic                            mul_en;
  logic [32:0]                     step;
  logic signed [32:0]              start_ext;
  logic signed [32:0]              sum;

  // One restoring division step and the complement of t.
  assign rem_dbl  = {rem, 1'b0};
  assign div_bit  = (rem_dbl >= {1'b0, dur});
  assign div_last = (cnt == esa_pkg::DIV_CNT_W'(esa_pkg::DIV_STEPS - 1));
  assign u        = esa_pkg::ONE_Q16 - {1'b0, quot};

  // Final add, truncated toward the start position.
  assign step      = prod[48:16];
  assign start_ext = {start[31], start};
  assign sum       = diff[32] ? (start_ext - $signed(step)) : (start_ext + $signed(step));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      esa_pkg::E_IDLE:   if (req.start) state_next = esa_pkg::E_DIV;
      esa_pkg::E_DIV:    if (div_last) state_next = esa_pkg::E_SQUARE;
      esa_pkg::E_SQUARE: state_next = esa_pkg::E_CUBE;
      esa_pkg::E_CUBE:   state_next = esa_pkg::E_EASE;
      esa_pkg::E_EASE:   state_next = esa_pkg::E_STEP;
      esa_pkg::E_STEP:   state_next = esa_pkg::E_ADD;
      esa_pkg::E_ADD:    state_next = esa_pkg::E_IDLE;
      default:           state_next = esa_pkg::E_IDLE;
    endcase
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      esa_pkg::E_SQUARE: begin
        mul_en = 1'b1;
        mul_a  = {16'b0, u};
        mul_b  = u;
      end
      esa_pkg::E_CUBE: begin
        mul_en = 1'b1;
        mul_a  = prod[32:0];
        mul_b  = u;
      end
      esa_pkg::E_STEP: begin
        mul_en = 1'b1;
        mul_a  = mag;
        mul_b  = eased;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esa_pkg::E_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      done  <= (state == esa_pkg::E_ADD);
      if (state == esa_pkg::E_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      esa_pkg::E_IDLE: begin
        if (req.start) begin
          rem    <= req.elapsed;
          dur    <= req.dur;
          quot   <= '0;
          start  <= req.glide_start;
          target <= req.glide_target;
        end
      end
      esa_pkg::E_DIV: begin
        rem  <= div_bit ? 16'(rem_dbl - {1'b0, dur}) : rem_dbl[15:0];
        quot <= {quot[14:0], div_bit};
      end
      esa_pkg::E_SQUARE: begin
        diff <= {target[31], target} - {start[31], start};
      end
      esa_pkg::E_EASE: begin
        eased <= esa_pkg::ONE_Q16 - prod[48:32];
        mag   <= diff[32] ? 33'(-diff) : diff;
      end
      esa_pkg::E_ADD: begin
        position <= sum[31:0];
      end
      default: begin
      end
    endcase
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign rsp.done     = done;
  assign rsp.position = position;

endmodule
